FILE: hw/rtl/tepp_pkg.sv
// types, codes and constants shared by the typed element packet parser
// no dependencies; compiled first
`default_nettype none

package tepp_pkg;

	// packet layout
	localparam int unsigned HEADER_BYTES     = 12;
	localparam int unsigned OPCODE_BYTES     = 4;
	localparam int unsigned MAX_VARINT_BYTES = 5;
	localparam int unsigned STRLEN_BYTES     = 2;

	// byte counter inside a field, wide enough for the header
	localparam int unsigned BIF_W = $clog2(HEADER_BYTES + 1);

	// result kinds
	localparam logic [2:0] KIND_HEADER    = 3'd0;
	localparam logic [2:0] KIND_SCALAR    = 3'd1;
	localparam logic [2:0] KIND_STR_START = 3'd2;
	localparam logic [2:0] KIND_STR_BYTE  = 3'd3;
	localparam logic [2:0] KIND_END_ONLY  = 3'd4;
	localparam logic [2:0] KIND_ERROR     = 3'd5;

	// error codes
	localparam logic [1:0] ERR_NONE      = 2'd0;
	localparam logic [1:0] ERR_UNKNOWN   = 2'd1;
	localparam logic [1:0] ERR_TRUNCATED = 2'd2;
	localparam logic [1:0] ERR_OVERLONG  = 2'd3;

	// element type codes
	localparam logic [2:0] TYPE_NONE  = 3'd0;
	localparam logic [2:0] TYPE_BE8   = 3'd1;
	localparam logic [2:0] TYPE_BE16  = 3'd2;
	localparam logic [2:0] TYPE_BE32  = 3'd3;
	localparam logic [2:0] TYPE_BE64  = 3'd4;
	localparam logic [2:0] TYPE_LE32  = 3'd5;
	localparam logic [2:0] TYPE_STR_A = 3'd6;
	localparam logic [2:0] TYPE_STR_B = 3'd7;

	typedef enum logic [3:0] {
		PH_HEADER,
		PH_BODYLEN,
		PH_COUNT,
		PH_PAD,
		PH_TYPE,
		PH_SCALAR,
		PH_STRLEN,
		PH_STRBYTES,
		PH_DONE,
		PH_DROP
	} tepp_phase_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       packet_end;
	} tepp_in_t;

	typedef struct packed {
		logic [2:0]  kind;
		logic [2:0]  elem_type;
		logic [31:0] opcode;
		logic [63:0] value;
		logic [15:0] str_length;
		logic [1:0]  error_code;
		logic        end_of_packet;
	} tepp_out_t;

	// queue status seen by the back end
	typedef struct packed {
		logic empty;
		logic full;
	} tepp_qstat_t;

	// payload size in bytes of a scalar type
	function automatic logic [BIF_W-1:0] scalar_bytes(input logic [2:0] t);
		logic [BIF_W-1:0] n;
		case (t)
			TYPE_BE8:  n = BIF_W'(1);
			TYPE_BE16: n = BIF_W'(2);
			TYPE_BE32: n = BIF_W'(4);
			TYPE_BE64: n = BIF_W'(8);
			TYPE_LE32: n = BIF_W'(4);
			default:   n = '0;
		endcase
		return n;
	endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/tepp_if.sv
// valid/ready channel interfaces for packet bytes and parse results
// depends on tepp_pkg
`default_nettype none

interface tepp_in_if import tepp_pkg::*; ();
	logic     valid;
	logic     ready;
	tepp_in_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface tepp_out_if import tepp_pkg::*; ();
	logic      valid;
	logic      ready;
	tepp_out_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/tepp_front.sv
// front end: per-byte packet state machine, at most one result per byte
// depends on tepp_pkg
`default_nettype none

module tepp_front import tepp_pkg::*; (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      take,
	input  wire tepp_in_t  item,
	output logic           push,
	output tepp_out_t      result
);

	tepp_phase_t      ph_q, ph_d;
	logic [BIF_W-1:0] bif_q, bif_d, bif_inc;
	logic [63:0]      acc_q, acc_d;
	logic [31:0]      opc_q, opc_d;
	logic [2:0]       vs_q, vs_d;
	logic [31:0]      elems_q, elems_d, elems_dec;
	logic [2:0]       cur_q, cur_d;
	logic [15:0]      strl_q, strl_d;
	logic             have, err;
	logic [7:0]       b;
	logic             last;
	tepp_out_t        r;

	assign b         = item.data_byte;
	assign last      = item.packet_end;
	assign bif_inc   = bif_q + BIF_W'(1);
	assign elems_dec = elems_q - 32'd1;

	always_comb begin
		ph_d    = ph_q;
		bif_d   = bif_q;
		acc_d   = acc_q;
		opc_d   = opc_q;
		vs_d    = vs_q;
		elems_d = elems_q;
		cur_d   = cur_q;
		strl_d  = strl_q;
		have    = 1'b0;
		err     = 1'b0;
		r       = '0;

		case (ph_q)
			PH_HEADER: begin
				if (bif_q < BIF_W'(OPCODE_BYTES))
					opc_d = {opc_q[23:0], b};
				else
					acc_d = {acc_q[55:0], b};
				bif_d = bif_inc;
				if (bif_inc >= BIF_W'(HEADER_BYTES)) begin
					have      = 1'b1;
					r.kind    = KIND_HEADER;
					r.opcode  = opc_d;
					r.value   = acc_d;
					bif_d     = '0;
					acc_d     = '0;
					vs_d      = '0;
					elems_d   = '0;
					ph_d      = last ? PH_DONE : PH_BODYLEN;
				end
			end
			PH_BODYLEN, PH_COUNT: begin
				if (ph_q == PH_COUNT)
					elems_d = elems_q | ({25'd0, b[6:0]} << (5'd7 * 5'(vs_q)));
				if (b[7]) begin
					if ((4'(vs_q) + 4'd1) >= 4'(MAX_VARINT_BYTES)) begin
						err          = 1'b1;
						r.error_code = ERR_OVERLONG;
					end else begin
						vs_d = vs_q + 3'd1;
					end
				end else begin
					vs_d = '0;
					ph_d = (ph_q == PH_BODYLEN) ? PH_COUNT : PH_PAD;
				end
			end
			PH_PAD: begin
				ph_d = (elems_q == 32'd0) ? PH_DONE : PH_TYPE;
			end
			PH_TYPE: begin
				if (b >= 8'd1 && b <= 8'd7) begin
					cur_d = b[2:0];
					bif_d = '0;
					acc_d = '0;
					ph_d  = (b[2:0] <= TYPE_LE32) ? PH_SCALAR : PH_STRLEN;
				end else begin
					err          = 1'b1;
					r.error_code = ERR_UNKNOWN;
				end
			end
			PH_SCALAR: begin
				if (cur_q == TYPE_LE32) begin
					if (bif_q < BIF_W'(4)) begin
						case (bif_q[1:0])
							2'd0:    acc_d[7:0]   = acc_q[7:0] | b;
							2'd1:    acc_d[15:8]  = acc_q[15:8] | b;
							2'd2:    acc_d[23:16] = acc_q[23:16] | b;
							default: acc_d[31:24] = acc_q[31:24] | b;
						endcase
					end
				end else begin
					acc_d = {acc_q[55:0], b};
				end
				bif_d = bif_inc;
				if (bif_inc >= scalar_bytes(cur_q)) begin
					have        = 1'b1;
					r.kind      = KIND_SCALAR;
					r.elem_type = cur_q;
					r.value     = acc_d;
					elems_d     = elems_dec;
					ph_d        = (elems_dec != 32'd0) ? PH_TYPE : PH_DONE;
				end
			end
			PH_STRLEN: begin
				acc_d = {acc_q[55:0], b};
				bif_d = bif_inc;
				if (bif_inc >= BIF_W'(STRLEN_BYTES)) begin
					strl_d       = acc_d[15:0];
					have         = 1'b1;
					r.kind       = KIND_STR_START;
					r.elem_type  = cur_q;
					r.str_length = acc_d[15:0];
					if (acc_d[15:0] == 16'd0) begin
						elems_d = elems_dec;
						ph_d    = (elems_dec != 32'd0) ? PH_TYPE : PH_DONE;
					end else begin
						ph_d = PH_STRBYTES;
					end
				end
			end
			PH_STRBYTES: begin
				have        = 1'b1;
				r.kind      = KIND_STR_BYTE;
				r.elem_type = cur_q;
				r.value     = {56'd0, b};
				strl_d      = strl_q - 16'd1;
				if (strl_d == 16'd0) begin
					elems_d = elems_dec;
					ph_d    = (elems_dec != 32'd0) ? PH_TYPE : PH_DONE;
				end
			end
			default: begin
			end
		endcase

		// error replaces the result and drops the rest of the packet
		if (err) begin
			have        = 1'b1;
			r.kind      = KIND_ERROR;
			r.elem_type = TYPE_NONE;
			r.opcode    = '0;
			r.value     = '0;
			r.str_length = '0;
			ph_d        = PH_DROP;
		end

		if (last) begin
			if (err) begin
				r.end_of_packet = 1'b1;
			end else if (ph_d == PH_DONE) begin
				if (!have) begin
					have   = 1'b1;
					r.kind = KIND_END_ONLY;
				end
				r.end_of_packet = 1'b1;
			end else if (ph_d == PH_DROP) begin
				have = 1'b0;
			end else begin
				have            = 1'b1;
				r               = '0;
				r.kind          = KIND_ERROR;
				r.error_code    = ERR_TRUNCATED;
				r.end_of_packet = 1'b1;
			end
			ph_d    = PH_HEADER;
			bif_d   = '0;
			acc_d   = '0;
			opc_d   = '0;
			vs_d    = '0;
			elems_d = '0;
			cur_d   = '0;
			strl_d  = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q    <= PH_HEADER;
			bif_q   <= '0;
			acc_q   <= '0;
			opc_q   <= '0;
			vs_q    <= '0;
			elems_q <= '0;
			cur_q   <= '0;
			strl_q  <= '0;
		end else if (take) begin
			ph_q    <= ph_d;
			bif_q   <= bif_d;
			acc_q   <= acc_d;
			opc_q   <= opc_d;
			vs_q    <= vs_d;
			elems_q <= elems_d;
			cur_q   <= cur_d;
			strl_q  <= strl_d;
		end
	end

	assign push   = take && have;
	assign result = r;

endmodule

`default_nettype wire

FILE: hw/rtl/tepp_queue.sv
// short result queue between front and back end, flop storage
// depends on tepp_pkg
`default_nettype none

module tepp_queue import tepp_pkg::*; #(
	parameter int unsigned DEPTH = 4
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        push,
	input  wire tepp_out_t   wdata,
	input  wire logic        pop,
	output tepp_out_t        rdata,
	output tepp_qstat_t      stat
);

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	tepp_out_t        mem_q [DEPTH];
	logic [PTR_W-1:0] wr_q, rd_q;
	logic [CNT_W-1:0] cnt_q;

	function automatic logic [PTR_W-1:0] wrap_inc(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
	endfunction

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_q] <= wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push)
				wr_q <= wrap_inc(wr_q);
			if (pop)
				rd_q <= wrap_inc(rd_q);
			if (push && !pop)
				cnt_q <= cnt_q + CNT_W'(1);
			else if (pop && !push)
				cnt_q <= cnt_q - CNT_W'(1);
		end
	end

	assign rdata = mem_q[rd_q];
	assign stat  = tepp_qstat_t'{empty: (cnt_q == '0), full: (cnt_q == CNT_W'(DEPTH))};

endmodule

`default_nettype wire

FILE: hw/rtl/tepp_back.sv
// back end: output register that drains the result queue
// depends on tepp_pkg, tepp_if
`default_nettype none

module tepp_back import tepp_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire tepp_qstat_t stat,
	input  wire tepp_out_t   head,
	output logic             pop,
	tepp_out_if.source       res
);

	logic      vld_q;
	tepp_out_t data_q;

	assign pop = !stat.empty && (!vld_q || res.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (!vld_q || res.ready) begin
			vld_q <= !stat.empty;
		end
	end

	always_ff @(posedge clk) begin
		if (pop)
			data_q <= head;
	end

	assign res.valid = vld_q;
	assign res.data  = data_q;

endmodule

`default_nettype wire

FILE: hw/rtl/typed_element_packet_parser_unit.sv
// typed element packet parser, top level: front end, result queue, back end
// depends on tepp_pkg, tepp_if, tepp_front, tepp_queue, tepp_back
// throughput: one byte per cycle while the queue is not full, set by the front end's registered state update
// result path: each result goes through the queue, then the back end's output register that drives res
// reset: arst_n clears parser state, empties the queue, drops the output valid
`default_nettype none

module typed_element_packet_parser_unit import tepp_pkg::*; #(
	parameter int unsigned QUEUE_DEPTH = 4
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	tepp_in_if.sink    pkt,
	tepp_out_if.source res
);

	logic        take;
	logic        push;
	logic        pop;
	tepp_out_t   front_res;
	tepp_out_t   head;
	tepp_qstat_t qstat;

	// bytes are taken whenever the queue has room, even while the back end
	// is stalled; at most one result per byte enters the queue
	assign pkt.ready = !qstat.full;
	assign take      = pkt.valid && pkt.ready;

	// per-byte parsing and classification
	tepp_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.take   (take),
		.item   (pkt.data),
		.push   (push),
		.result (front_res)
	);

	// decouples the parser from output backpressure
	tepp_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (front_res),
		.pop    (pop),
		.rdata  (head),
		.stat   (qstat)
	);

	// registered result transaction toward the consumer
	tepp_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.stat   (qstat),
		.head   (head),
		.pop    (pop),
		.res    (res)
	);

endmodule

`default_nettype wire
